@@ design/dtbf_pkg.sv @@
// Shared types, constants and helpers of the disk track bit-stream formatter.
package dtbf_pkg;

   localparam int SECTOR_BYTES    = 2048;
   localparam int PREAMBLE_BYTES  = 248;
   localparam int GAP_BYTES       = 32;
   localparam int WORD_BITS       = 64;
   localparam int FRAME_BITS      = 11;
   localparam int PREAMBLE_WORDS  = PREAMBLE_BYTES * 8 / WORD_BITS;
   localparam int GAP_WORDS       = GAP_BYTES * 8 / WORD_BITS;
   localparam int TRACK_WORDS_MAX = 432;
   localparam int MAX_RESULTS     = 64;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int BYTE_COUNT_W    = $clog2(SECTOR_BYTES);
   localparam int CSR_INDEX_W     = 1;
   localparam int CSR_DATA_W      = 16;

   localparam logic [7:0] SECTOR_PAGES = 8'(SECTOR_BYTES / 256);
   localparam logic [7:0] MARK_SYNC0   = 8'h43;
   localparam logic [7:0] MARK_SYNC1   = 8'h57;
   localparam logic [7:0] MARK_SYNC2   = 8'h58;
   localparam logic [7:0] MARK_SECT0   = 8'h76;
   localparam logic [7:0] MARK_SECT1   = 8'h01;
   localparam logic [7:0] MARK_SECT2   = 8'h08;
   localparam logic [7:0] MARK_END0    = 8'h47;
   localparam logic [7:0] MARK_END1    = 8'h53;

   localparam logic [15:0] BOOT_ADDR_RESET = 16'h2200;
   localparam logic [8:0]  TRACK_LEN_RESET = 9'd416;

   localparam logic [CSR_INDEX_W-1:0] CSR_BOOT_ADDR = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TRACK_LEN = 1'b1;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   typedef struct packed {
      logic       command;
      logic [6:0] track_number;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] track_word;
      logic                 last_of_run;
      logic                 last_of_track;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_START,
      OP_DATA,
      OP_CLOSE
   } op_kind_type;

   typedef struct packed {
      op_kind_type kind;
      logic        boot;
      logic [7:0]  value;
   } op_type;

   typedef struct packed {
      logic   valid;
      op_type op;
   } push_type;

   // tens by reciprocal multiply, good for the whole 7-bit range
   function automatic logic [7:0] bcd_of(input logic [6:0] trk);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [3:0]  ones;
      prod     = 15'(trk) * 15'd205;
      tens     = prod[14:11];
      tens_x10 = 7'({tens, 3'b000}) + 7'({tens, 1'b0});
      ones     = 4'(trk - tens_x10);
      return {tens, ones};
   endfunction

endpackage

@@ design/disk_track_bitstream_formatter.sv @@
// Top level of the disk track bit-stream formatter: CSRs, front end, queue and back end.
// Data byte: one byte per cycle sustained while the back end is idle and the output is not stalled.
// Start track: a setup step, then one preamble or header step per cycle unless the output stalls
//    (31 + 3 or 11 steps), giving 31 or 36 words; the sequencer in the back end sets this.
// Track close: data frame, trailers if not boot, pad words (one per cycle unless stalled) to length, 64 words at most.
// Reset: synchronous; clears queue, track state and response valid, CSRs return to 0x2200 and 416.
module disk_track_bitstream_formatter (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  dtbf_pkg::req_type                    req,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output dtbf_pkg::rsp_type                    rsp,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [dtbf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [dtbf_pkg::CSR_DATA_W-1:0]      csr_data
);
   import dtbf_pkg::*;

   logic [15:0] boot_addr_ff;
   logic [8:0]  track_len_ff;
   push_type    push;
   logic        q_full, pop, head_valid;
   op_type      head;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_addr_ff <= BOOT_ADDR_RESET;
         track_len_ff <= TRACK_LEN_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BOOT_ADDR: boot_addr_ff <= csr_data[15:0];
            CSR_TRACK_LEN: track_len_ff <= csr_data[8:0];
            default:       boot_addr_ff <= boot_addr_ff;
         endcase
      end
   end

   dtbf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .q_full    (q_full),
      .push      (push)
   );

   dtbf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .q_full     (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   dtbf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .boot_addr  (boot_addr_ff),
      .track_len  (track_len_ff),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp        (rsp)
   );

endmodule

@@ design/dtbf_front.sv @@
// Front end: accepts request transactions, tracks the open track and classifies items.
module dtbf_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dtbf_pkg::req_type req,
   input  logic              q_full,
   output dtbf_pkg::push_type push
);
   import dtbf_pkg::*;

   logic                    open_ff, open_in;
   logic [BYTE_COUNT_W-1:0] count_ff, count_in;
   logic                    accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      push     = '0;
      open_in  = open_ff;
      count_in = count_ff;
      if (accept) begin
         if (req.command == CMD_START) begin
            push.valid    = 1'b1;
            push.op.kind  = OP_START;
            push.op.boot  = (req.track_number == 7'd0);
            push.op.value = bcd_of(req.track_number);
            open_in       = 1'b1;
            count_in      = '0;
         end else if (open_ff) begin
            push.valid    = 1'b1;
            push.op.value = req.data_byte;
            if (count_ff == BYTE_COUNT_W'(SECTOR_BYTES - 1)) begin
               push.op.kind = OP_CLOSE;
               open_in      = 1'b0;
               count_in     = '0;
            end else begin
               push.op.kind = OP_DATA;
               count_in     = count_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         open_ff  <= open_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_stray_dropped: assert property (@(posedge clock) disable iff (reset)
      (accept && req.command == CMD_DATA && !open_ff) |-> !push.valid)
      else $error("data byte queued with no open track");
`endif

endmodule

@@ design/dtbf_queue.sv @@
// Short operation queue between the front end and the bit packer.
module dtbf_queue (
   input  logic               clock,
   input  logic               reset,
   input  dtbf_pkg::push_type push,
   output logic               q_full,
   input  logic               pop,
   output logic               head_valid,
   output dtbf_pkg::op_type   head
);
   import dtbf_pkg::*;

   op_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign q_full     = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && !q_full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.op;
      end
   end

`ifndef SYNTHESIS
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !push.valid)
      else $error("push into full queue");
`endif

endmodule

@@ design/dtbf_back.sv @@
// Back end: header sequencer, bit packer, word hold stage and response register.
module dtbf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              head_valid,
   input  dtbf_pkg::op_type  head,
   output logic              pop,
   input  logic [15:0]       boot_addr,
   input  logic [8:0]        track_len,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dtbf_pkg::rsp_type rsp
);
   import dtbf_pkg::*;

   localparam int CNT_W = 5;
   localparam int WIN_W = 2 * WORD_BITS;

   localparam logic [CNT_W-1:0] PREAMBLE_LAST = CNT_W'(PREAMBLE_WORDS - 1);
   localparam logic [CNT_W-1:0] HDR_ADDR_LO   = CNT_W'(0);
   localparam logic [CNT_W-1:0] HDR_ADDR_HI   = CNT_W'(1);
   localparam logic [CNT_W-1:0] HDR_SYNC0     = CNT_W'(0);
   localparam logic [CNT_W-1:0] HDR_SYNC1     = CNT_W'(1);
   localparam logic [CNT_W-1:0] HDR_TRACK     = CNT_W'(2);
   localparam logic [CNT_W-1:0] HDR_SYNC2     = CNT_W'(3);
   localparam logic [CNT_W-1:0] HDR_GAP_FIRST = CNT_W'(4);
   localparam logic [CNT_W-1:0] HDR_GAP_END   = CNT_W'(4 + GAP_WORDS);
   localparam logic [CNT_W-1:0] HDR_SECT1     = CNT_W'(5 + GAP_WORDS);
   localparam logic [CNT_W-1:0] TRAIL_LAST    = CNT_W'(1);
   localparam logic [5:0]       RUN_LAST      = 6'(MAX_RESULTS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PRE,
      ST_HDR,
      ST_TRAIL,
      ST_PAD
   } state_type;

   typedef enum logic [2:0] {
      SK_NONE,
      SK_INIT,
      SK_FRAME,
      SK_ONES,
      SK_FLUSH
   } step_kind_type;

   function automatic logic [FRAME_BITS-1:0] frame_bits(input logic [7:0] value);
      logic [FRAME_BITS-1:0] f;
      f[FRAME_BITS-1] = 1'b0;
      for (int i = 0; i < 8; i++) begin
         f[FRAME_BITS-2-i] = value[i];
      end
      f[1] = ^value;
      f[0] = 1'b1;
      return f;
   endfunction

   state_type            state_ff, state_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 boot_ff, boot_in;
   logic [7:0]           bcd_ff, bcd_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [5:0]           fill_ff, fill_in;
   logic [8:0]           words_ff, words_in;
   logic [5:0]           run_ff, run_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic                 pend_final_ff, pend_final_in;
   logic                 pend_track_ff, pend_track_in;
   logic [WORD_BITS-1:0] pend_word_ff, pend_word_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_ff, rsp_in;

   step_kind_type        step_kind;
   logic [7:0]           step_byte;
   logic                 step_final, step_track;
   logic                 step_emits, step_fire, out_free, pend_out;
   logic [6:0]           fill_sum, shamt;
   logic [WIN_W-1:0]     fmask, fval, packed_w;
   logic [WORD_BITS-1:0] emit_word;
   logic [8:0]           len_eff;

   assign len_eff  = (track_len > 9'(TRACK_WORDS_MAX)) ? 9'(TRACK_WORDS_MAX) : track_len;
   assign fill_sum = {1'b0, fill_ff} + 7'(FRAME_BITS);
   assign shamt    = 7'(WIN_W - FRAME_BITS) - {1'b0, fill_ff};
   assign fmask    = {{(WIN_W-FRAME_BITS){1'b0}}, {FRAME_BITS{1'b1}}} << shamt;
   assign fval     = {{(WIN_W-FRAME_BITS){1'b0}}, frame_bits(step_byte)} << shamt;
   assign packed_w = ({acc_ff, {WORD_BITS{1'b1}}} & ~fmask) | fval;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // step decode
   always_comb begin
      step_kind  = SK_NONE;
      step_byte  = '0;
      step_final = 1'b0;
      step_track = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               step_byte = head.value;
               unique case (head.kind)
                  OP_START: step_kind = SK_INIT;
                  OP_DATA: begin
                     step_kind  = SK_FRAME;
                     step_final = 1'b1;
                  end
                  OP_CLOSE: step_kind = SK_FRAME;
                  default:  step_kind = SK_NONE;
               endcase
            end
         end
         ST_PRE: step_kind = SK_ONES;
         ST_HDR: begin
            step_kind = SK_FRAME;
            if (boot_ff) begin
               priority if (cnt_ff == HDR_ADDR_LO) begin
                  step_byte = boot_addr[7:0];
               end else if (cnt_ff == HDR_ADDR_HI) begin
                  step_byte = boot_addr[15:8];
               end else begin
                  step_byte  = SECTOR_PAGES;
                  step_final = 1'b1;
               end
            end else if (cnt_ff >= HDR_GAP_FIRST && cnt_ff < HDR_GAP_END) begin
               step_kind = SK_ONES;
            end else begin
               unique case (cnt_ff)
                  HDR_SYNC0:   step_byte = MARK_SYNC0;
                  HDR_SYNC1:   step_byte = MARK_SYNC1;
                  HDR_TRACK:   step_byte = bcd_ff;
                  HDR_SYNC2:   step_byte = MARK_SYNC2;
                  HDR_GAP_END: step_byte = MARK_SECT0;
                  HDR_SECT1:   step_byte = MARK_SECT1;
                  default: begin
                     step_byte  = MARK_SECT2;
                     step_final = 1'b1;
                  end
               endcase
            end
         end
         ST_TRAIL: begin
            step_kind = SK_FRAME;
            step_byte = (cnt_ff == TRAIL_LAST) ? MARK_END1 : MARK_END0;
         end
         ST_PAD: begin
            step_kind  = SK_FLUSH;
            // padding also ends at the per-transaction word limit
            step_final = (({1'b0, words_ff} + 10'd1) >= {1'b0, len_eff}) ||
                         (run_ff == RUN_LAST);
            step_track = step_final;
         end
         default: step_kind = SK_NONE;
      endcase
   end

   always_comb begin
      unique case (step_kind)
         SK_FRAME:         step_emits = fill_sum[6];
         SK_ONES, SK_FLUSH: step_emits = 1'b1;
         default:          step_emits = 1'b0;
      endcase
   end

   assign step_fire = (step_kind != SK_NONE) && (!step_emits || !pend_valid_ff || out_free);
   assign pend_out  = pend_valid_ff && out_free && (pend_final_ff || (step_fire && step_emits));
   assign pop       = step_fire && (state_ff == ST_IDLE);
   assign emit_word = (step_kind == SK_FRAME) ? packed_w[WIN_W-1:WORD_BITS] : acc_ff;

   // datapath and sequencing
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      boot_in  = boot_ff;
      bcd_in   = bcd_ff;
      acc_in   = acc_ff;
      fill_in  = fill_ff;
      words_in = words_ff;
      run_in   = run_ff;
      if (step_fire) begin
         if (step_emits) begin
            words_in = words_ff + 1'b1;
            run_in   = run_ff + 1'b1;
         end
         unique case (step_kind)
            SK_INIT: begin
               acc_in   = '1;
               fill_in  = '0;
               words_in = '0;
               boot_in  = head.boot;
               bcd_in   = head.value;
            end
            SK_FRAME: begin
               acc_in  = step_emits ? packed_w[WORD_BITS-1:0] : packed_w[WIN_W-1:WORD_BITS];
               fill_in = fill_sum[5:0];
            end
            SK_ONES: acc_in = '1;
            SK_FLUSH: begin
               acc_in  = '1;
               fill_in = '0;
            end
            default: acc_in = acc_ff;
         endcase
         unique case (state_ff)
            ST_IDLE: begin
               cnt_in = '0;
               run_in = {5'd0, step_emits};
               if (head.kind == OP_START) begin
                  state_in = ST_PRE;
               end else if (head.kind == OP_CLOSE) begin
                  state_in = boot_ff ? ST_PAD : ST_TRAIL;
               end
            end
            ST_PRE: begin
               if (cnt_ff == PREAMBLE_LAST) begin
                  state_in = ST_HDR;
                  cnt_in   = '0;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            ST_HDR: begin
               cnt_in = cnt_ff + 1'b1;
               if (step_final) begin
                  state_in = ST_IDLE;
               end
            end
            ST_TRAIL: begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == TRAIL_LAST) begin
                  state_in = ST_PAD;
               end
            end
            ST_PAD: begin
               if (step_final) begin
                  state_in = ST_IDLE;
               end
            end
            default: state_in = ST_IDLE;
         endcase
      end
   end

   // hold stage: a word waits until it is known whether it ends its transaction
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_final_in = pend_final_ff;
      pend_track_in = pend_track_ff;
      pend_word_in  = pend_word_ff;
      if (step_fire && step_emits) begin
         pend_valid_in = 1'b1;
         pend_final_in = step_final;
         pend_track_in = step_track;
         pend_word_in  = emit_word;
      end else if (pend_out) begin
         pend_valid_in = 1'b0;
      end else if (step_fire && step_final && pend_valid_ff) begin
         pend_final_in = 1'b1;
      end
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (pend_out) begin
         rsp_valid_in         = 1'b1;
         rsp_in.track_word    = pend_word_ff;
         rsp_in.last_of_run   = pend_final_ff;
         rsp_in.last_of_track = pend_track_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cnt_ff        <= '0;
         boot_ff       <= 1'b0;
         acc_ff        <= '1;
         fill_ff       <= '0;
         words_ff      <= '0;
         run_ff        <= '0;
         pend_valid_ff <= 1'b0;
         pend_final_ff <= 1'b0;
         pend_track_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         boot_ff       <= boot_in;
         bcd_ff        <= bcd_in;
         acc_ff        <= acc_in;
         fill_ff       <= fill_in;
         words_ff      <= words_in;
         run_ff        <= run_in;
         pend_valid_ff <= pend_valid_in;
         pend_final_ff <= pend_final_in;
         pend_track_ff <= pend_track_in;
         pend_word_ff  <= pend_word_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_ff        <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

`ifndef SYNTHESIS
   a_track_end_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last_of_track) |-> rsp_ff.last_of_run)
      else $error("track end without run end");
   a_idle_hold_final: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && pend_valid_ff) |-> pend_final_ff)
      else $error("held word not closed at idle");
   a_preamble_aligned: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRE) |-> (fill_ff == '0))
      else $error("preamble not word aligned");
`endif

endmodule
